// ===== hw/rtl/mprm_pkg.sv =====
// ----------------------------------------------------------------------------
// Pulse rate meter package
// Shared sizes, command encoding and the decoded command type of the
// multichannel pulse rate meter.
// ----------------------------------------------------------------------------
`default_nettype none

package mprm_pkg;

    // Channel and window geometry.
    localparam int CHANNELS   = 16;
    localparam int WINDOW     = 16;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WIN_SHIFT  = $clog2(WINDOW + 1) - 1;
    localparam int SNAP_AW    = CH_IDX_W + POS_W;
    localparam int SNAP_DEPTH = 1 << SNAP_AW;

    // Field widths on the stream ports.
    localparam int FUNC_W     = 2;
    localparam int CHAN_W     = 4;
    localparam int COUNT_W    = 32;
    localparam int RATE_W     = 16;
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 8;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 8;

    // Timing state and configuration.
    localparam int ELAPSED_W                 = 17;
    localparam int INTERVAL_W                = 16;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;
    localparam logic [COUNT_W-1:0]    RATE_SCALE     = 32'd100;

    // Command codes as carried in tuser.
    typedef enum logic [FUNC_W-1:0] {
        OP_PULSE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_TICK  = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // Decoded command handed from the front end to the back end.
    typedef struct packed {
        t_op                 op;
        logic [CH_IDX_W-1:0] ch;
        logic                ch_ok;
    } t_cmd;

endpackage

`default_nettype wire

// ===== hw/rtl/mprm_front.sv =====
// ----------------------------------------------------------------------------
// Pulse rate meter front end
// Decodes each input beat and checks its channel range into a register
// stage, then pushes the decoded command into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mprm_front
    import mprm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] i_s_axis_tdata,
    input  wire logic [IN_USER_W-1:0] i_s_axis_tuser,
    output logic                      o_push,
    output t_cmd                      o_cmd,
    input  wire logic                 i_full
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic [CHAN_W-1:0] chan;

    // The stage takes a beat when it is empty or its content moves on.
    assign o_s_axis_tready = !r_valid || !i_full;
    assign o_push          = r_valid && !i_full;
    assign o_cmd           = r_cmd;

    // Decode the command and check the channel against the channel count.
    always_comb begin
        chan        = i_s_axis_tdata[CHAN_W-1:0];
        n_cmd.op    = t_op'(i_s_axis_tuser[FUNC_W-1:0]);
        n_cmd.ch    = CH_IDX_W'(chan);
        n_cmd.ch_ok = (32'(chan) < CHANNELS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mprm_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Pulse rate meter command queue
// Two-entry queue of decoded commands between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mprm_cmd_fifo
    import mprm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mprm_back.sv =====
// ----------------------------------------------------------------------------
// Pulse rate meter back end
// Executes commands: keeps the counts, rates, tick counter and snapshot
// memory, walks all channels on a rate update and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mprm_back
    import mprm_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [INTERVAL_W-1:0]   i_cfg_wdata,
    input  wire logic                    i_cmd_valid,
    input  wire t_cmd                    i_cmd,
    output logic                         o_pop,
    output logic                         o_m_axis_tvalid,
    input  wire logic                    i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]        o_m_axis_tdata,
    output logic [OUT_USER_W-1:0]        o_m_axis_tuser
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_SUB  = 5'b00100,
        S_MUL  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [COUNT_W-1:0]    r_counts [CHANNELS];
    logic [RATE_W-1:0]     r_rates  [CHANNELS];
    logic [COUNT_W-1:0]    r_snap_mem [SNAP_DEPTH];
    logic [SNAP_DEPTH-1:0] r_snap_ok;
    logic [COUNT_W-1:0]    r_snap_q;
    logic                  r_snap_q_ok;

    logic [POS_W-1:0]      r_pos;
    logic [CH_IDX_W-1:0]   r_uch;
    logic [ELAPSED_W-1:0]  r_elapsed;
    logic [INTERVAL_W-1:0] r_interval;
    t_cmd                  r_cmd;
    logic [COUNT_W-1:0]    r_diff;

    logic                  r_out_valid;
    logic [COUNT_W-1:0]    r_out_count;
    logic [RATE_W-1:0]     r_out_rate;
    logic                  r_out_upd;

    logic [CH_IDX_W-1:0]   cnt_idx;
    logic [CH_IDX_W-1:0]   rate_idx;
    logic [COUNT_W-1:0]    cnt_rd;
    logic [RATE_W-1:0]     rate_rd;
    logic [ELAPSED_W-1:0]  elapsed_inc;
    logic                  do_update;
    logic                  out_free;
    logic                  load;
    logic [COUNT_W-1:0]    ld_count;
    logic [RATE_W-1:0]     ld_rate;
    logic                  ld_upd;
    logic [SNAP_AW-1:0]    snap_addr;
    logic [COUNT_W-1:0]    snap_val;
    logic [COUNT_W-1:0]    prod;
    logic [RATE_W-1:0]     rate_new;
    logic                  last_ch;

    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign snap_addr = {r_uch, r_pos};
    assign snap_val  = r_snap_q_ok ? r_snap_q : '0;
    assign last_ch   = (r_uch == CH_IDX_W'(CHANNELS - 1));

    // Shared read ports of the count and rate registers.
    always_comb begin
        case (r_state)
            S_SUB:   cnt_idx = r_uch;
            S_FIN:   cnt_idx = r_cmd.ch;
            default: cnt_idx = i_cmd.ch;
        endcase
        rate_idx = (r_state == S_FIN) ? r_cmd.ch : i_cmd.ch;
        cnt_rd   = r_counts[cnt_idx];
        rate_rd  = r_rates[rate_idx];
    end

    // Saturating tick count and update decision.
    always_comb begin
        elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
        do_update   = (elapsed_inc > ELAPSED_W'(r_interval));
    end

    // Scaled window difference to rate.
    always_comb begin
        prod     = r_diff * RATE_SCALE;
        rate_new = prod[WIN_SHIFT +: RATE_W];
    end

    // Sequencer and result selection.
    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load     = 1'b0;
        ld_count = '0;
        ld_rate  = '0;
        ld_upd   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_pop = 1'b1;
                    if (i_cmd.op == OP_TICK && do_update) begin
                        n_state = S_RD;
                    end else begin
                        load = 1'b1;
                        if (i_cmd.ch_ok) begin
                            case (i_cmd.op)
                                OP_PULSE: ld_count = cnt_rd + 1'b1;
                                OP_CLEAR: ld_count = '0;
                                default:  ld_count = cnt_rd;
                            endcase
                            ld_rate = rate_rd;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_SUB;
            end
            S_SUB: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = last_ch ? S_FIN : S_RD;
            end
            S_FIN: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_upd  = 1'b1;
                    n_state = S_IDLE;
                    if (r_cmd.ch_ok) begin
                        ld_count = cnt_rd;
                        ld_rate  = rate_rd;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, counts, rates and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= '0;
            r_uch      <= '0;
            r_elapsed  <= '0;
            r_interval <= INTERVAL_RESET;
            for (int c = 0; c < CHANNELS; c++) begin
                r_counts[c] <= '0;
                r_rates[c]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
            if (o_pop) begin
                case (i_cmd.op)
                    OP_PULSE: begin
                        if (i_cmd.ch_ok) begin
                            r_counts[i_cmd.ch] <= cnt_rd + 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        if (i_cmd.ch_ok) begin
                            r_counts[i_cmd.ch] <= '0;
                        end
                    end
                    OP_TICK: begin
                        r_elapsed <= do_update ? '0 : elapsed_inc;
                        r_uch     <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == S_MUL) begin
                r_rates[r_uch] <= rate_new;
                if (last_ch) begin
                    r_pos <= (r_pos == POS_W'(WINDOW - 1)) ? '0 : r_pos + 1'b1;
                end else begin
                    r_uch <= r_uch + 1'b1;
                end
            end
        end
    end

    // Snapshot valid bits: reset and channel clear empty them, updates fill them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_ok <= '0;
        end else if (o_pop && i_cmd.op == OP_CLEAR && i_cmd.ch_ok) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_snap_ok[{i_cmd.ch, POS_W'(i)}] <= 1'b0;
            end
        end else if (r_state == S_SUB) begin
            r_snap_ok[snap_addr] <= 1'b1;
        end
    end

    // Snapshot memory with registered read.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SUB) begin
            r_snap_mem[snap_addr] <= cnt_rd;
        end
        if (r_state == S_RD) begin
            r_snap_q    <= r_snap_mem[snap_addr];
            r_snap_q_ok <= r_snap_ok[snap_addr];
        end
    end

    // Command hold and window difference.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_SUB) begin
            r_diff <= cnt_rd - snap_val;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_count <= ld_count;
            r_out_rate  <= ld_rate;
            r_out_upd   <= ld_upd;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_rate, r_out_count};
    assign o_m_axis_tuser  = OUT_USER_W'(r_out_upd);

endmodule

`default_nettype wire

// ===== hw/rtl/multichannel_pulse_rate_meter_unit.sv =====
// ----------------------------------------------------------------------------
// Multichannel pulse rate meter
// Per-channel pulse counters with a sliding-window rate computed on a
// configurable millisecond interval.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry the command kind in tuser (pulse, clear, tick, read)
//   and the channel in tdata. Each beat yields exactly one output beat with
//   the channel's count and its latest rate in tdata, and in tuser a flag
//   telling whether the beat was a tick that ran a rate update.
//   The update interval register is written through i_cfg_we/i_cfg_wdata;
//   the user must write it only while the block is idle, which the block
//   itself does not enforce. An ordinary beat passes through the input
//   register, the queue and the result register, and such beats flow at
//   one per cycle while the receiver takes them. A tick that runs an
//   update walks every channel through the snapshot memory (read,
//   subtract, multiply for each) before the next beat runs.
//   Reset is synchronous: counts, rates, snapshots, ring position and tick
//   count go to zero and the interval to 1000; no clearing pass is needed.
//   When the receiver stalls the result register holds, the queue fills and
//   tready falls once the input register is occupied as well.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_pulse_rate_meter_unit
    import mprm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [INTERVAL_W-1:0] i_cfg_wdata,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // tdata: channel [3:0], zero [7:4]
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: func [1:0], zero [7:2]
    input  wire logic [IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // tdata: count [31:0], rate [47:32]
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    // tuser: updated [0], zero [7:1]
    output logic [OUT_USER_W-1:0]      o_m_axis_tuser
);

    logic push;
    logic full;
    logic pop;
    logic head_valid;
    t_cmd push_cmd;
    t_cmd head_cmd;

    mprm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_push          (push),
        .o_cmd           (push_cmd),
        .i_full          (full)
    );

    mprm_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    mprm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd_valid     (head_valid),
        .i_cmd           (head_cmd),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== dv/mprm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse rate meter checker
// Watches the input, output and configuration ports of the pulse rate meter.
// It keeps its own copy of the counts, rates, snapshot rings and tick timer,
// predicts one reading per accepted input beat, and compares each output
// beat field by field with the oldest predicted reading.
// ----------------------------------------------------------------------------

module mprm_checker
    import mprm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [INTERVAL_W-1:0] i_cfg_wdata,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    // channel [3:0], zero [7:4]
    input  wire logic [IN_DATA_W-1:0]  i_in_data,
    // func [1:0], zero [7:2]
    input  wire logic [IN_USER_W-1:0]  i_in_user,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    // count [31:0], rate [47:32]
    input  wire logic [OUT_DATA_W-1:0] i_out_data,
    // updated [0], zero [7:1]
    input  wire logic [OUT_USER_W-1:0] i_out_user,
    output int                         o_fail_count,
    output int                         o_pending
);

    // The shift that divides by the window length: floor(log2(WINDOW)).
    localparam int RATE_SHIFT = $clog2(WINDOW + 1) - 1;
    localparam logic [ELAPSED_W-1:0] TICKS_SAT = {ELAPSED_W{1'b1}};

    // One reading as it leaves the block: the flag above count and rate.
    typedef struct packed {
        logic               updated;
        logic [RATE_W-1:0]  rate;
        logic [COUNT_W-1:0] count;
    } t_reading;

    // Shadow state of the meter.
    logic [COUNT_W-1:0]    pulse_count [CHANNELS];
    logic [RATE_W-1:0]     chan_rate [CHANNELS];
    logic [COUNT_W-1:0]    snap_ring [CHANNELS][WINDOW];
    int                    ring_pos;
    logic [ELAPSED_W-1:0]  tick_count;
    logic [INTERVAL_W-1:0] interval;

    t_reading pending_readings [$];
    int       mismatches = 0;
    int       reading_idx = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] reading %0d: %s", $time, reading_idx, msg);
        mismatches++;
    endtask

    // Recompute every channel's rate over the window and take a new snapshot.
    function automatic void refresh_rates();
        logic [COUNT_W-1:0] diff;
        logic [COUNT_W-1:0] prod;
        for (int c = 0; c < CHANNELS; c++) begin
            diff = pulse_count[c] - snap_ring[c][ring_pos];
            prod = diff * 32'd100;
            chan_rate[c] = RATE_W'(prod >> RATE_SHIFT);
            snap_ring[c][ring_pos] = pulse_count[c];
        end
        ring_pos = (ring_pos + 1) % WINDOW;
    endfunction

    // Apply one command to the shadow state and return the reading it gives.
    function automatic t_reading advance_meter(input t_op op, input logic [CHAN_W-1:0] ch);
        t_reading r;
        logic     ch_ok;
        ch_ok = (int'(ch) < CHANNELS);
        r.updated = 1'b0;
        case (op)
            OP_PULSE: begin
                if (ch_ok) pulse_count[ch] = pulse_count[ch] + 1'b1;
            end
            OP_CLEAR: begin
                // Clearing zeroes the count and the ring but keeps the rate.
                if (ch_ok) begin
                    pulse_count[ch] = '0;
                    for (int w = 0; w < WINDOW; w++) snap_ring[ch][w] = '0;
                end
            end
            OP_TICK: begin
                if (tick_count != TICKS_SAT) tick_count = tick_count + 1'b1;
                if (tick_count > ELAPSED_W'(interval)) begin
                    tick_count = '0;
                    refresh_rates();
                    r.updated = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.count = ch_ok ? pulse_count[ch] : '0;
        r.rate  = ch_ok ? chan_rate[ch] : '0;
        return r;
    endfunction

    // Track configuration and accepted beats, then check the output beat.
    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                pulse_count[c] = '0;
                chan_rate[c] = '0;
                for (int w = 0; w < WINDOW; w++) snap_ring[c][w] = '0;
            end
            ring_pos = 0;
            tick_count = '0;
            interval = INTERVAL_RESET;
            pending_readings.delete();
        end else begin
            if (i_cfg_we) interval = i_cfg_wdata;
            if (i_in_valid && i_in_ready) begin
                pending_readings.push_back(advance_meter(t_op'(i_in_user[FUNC_W-1:0]),
                                                         i_in_data[CHAN_W-1:0]));
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_out_user[0], i_out_data[RATE_W+COUNT_W-1:0]};
                if (pending_readings.size() == 0) begin
                    report_mismatch("output beat with no reading expected");
                end else begin
                    want = pending_readings.pop_front();
                    if (got.count !== want.count) begin
                        report_mismatch($sformatf("count got %0d, expected %0d",
                                                  got.count, want.count));
                    end
                    if (got.rate !== want.rate) begin
                        report_mismatch($sformatf("rate got %0d, expected %0d",
                                                  got.rate, want.rate));
                    end
                    if (got.updated !== want.updated) begin
                        report_mismatch($sformatf("updated got %0b, expected %0b",
                                                  got.updated, want.updated));
                    end
                end
                reading_idx++;
            end
        end
        o_fail_count <= mismatches;
        o_pending <= pending_readings.size();
    end

endmodule

// ===== dv/tb_multichannel_pulse_rate_meter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse rate meter testbench
// Drives command beats into the pulse rate meter with random gaps and output
// stalls, walks the update interval through its reset value, zero, one, small
// values, a random one and the maximum, and leaves checking to the checker.
// ----------------------------------------------------------------------------

module tb_multichannel_pulse_rate_meter_unit;
    import mprm_pkg::*;

    localparam int TIMEOUT_NS = 4_000_000;
    localparam int LONG_HOLD  = 400;
    localparam int DRAIN_MAX  = 100_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [INTERVAL_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tready = 1'b0;
    wire logic                  s_tready;
    wire logic                  m_tvalid;
    wire logic [OUT_DATA_W-1:0] m_tdata;
    wire logic [OUT_USER_W-1:0] m_tuser;

    int fail_count;
    int pending;
    bit no_idle = 1'b0;
    bit long_hold_req = 1'b0;

    always #1 i_clk = ~i_clk;

    multichannel_pulse_rate_meter_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    mprm_checker rate_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_data    (s_tdata),
        .i_in_user    (s_tuser),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .i_out_user   (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    // Offer one command beat after a random gap and wait for its acceptance.
    task automatic send_beat(input t_op op, input logic [CHAN_W-1:0] ch);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_DATA_W'(ch);
        s_tuser <= IN_USER_W'(op);
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Mostly pulses and ticks, with reads and the odd clear.
    task automatic send_random_beat();
        int   pick;
        t_op  op;
        pick = $urandom_range(0, 99);
        if (pick < 45) op = OP_PULSE;
        else if (pick < 50) op = OP_CLEAR;
        else if (pick < 78) op = OP_TICK;
        else op = OP_READ;
        send_beat(op, CHAN_W'($urandom_range(0, CHANNELS - 1)));
    endtask

    // Back-to-back ticks with pulses sprinkled in.
    task automatic send_tick_run(input int ticks);
        no_idle = 1'b1;
        for (int i = 0; i < ticks; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                send_beat(OP_PULSE, CHAN_W'($urandom_range(0, CHANNELS - 1)));
            end
            send_beat(OP_TICK, CHAN_W'($urandom_range(0, CHANNELS - 1)));
        end
        no_idle = 1'b0;
    endtask

    // Let the block drain completely, then write the interval register.
    task automatic write_interval(input logic [INTERVAL_W-1:0] value);
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Result sink: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD;
            end else begin
                stall = draw_gap();
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    // Command stream and verdict.
    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A short tick run stays below the reset interval of 1000.
        send_tick_run(100);

        // Directed beats with an update every second tick.
        write_interval(16'd1);
        send_beat(OP_PULSE, 4'd0);
        send_beat(OP_PULSE, 4'd0);
        send_beat(OP_PULSE, 4'd0);
        send_beat(OP_PULSE, 4'd15);
        send_beat(OP_PULSE, 4'd15);
        send_beat(OP_READ, 4'd15);
        send_beat(OP_READ, 4'd0);
        send_beat(OP_TICK, 4'd0);
        send_beat(OP_TICK, 4'd15);
        send_beat(OP_READ, 4'd0);
        // Clearing keeps the last rate but zeroes the count and the ring.
        send_beat(OP_CLEAR, 4'd0);
        send_beat(OP_READ, 4'd0);
        send_beat(OP_PULSE, 4'd0);
        send_beat(OP_TICK, 4'd5);
        send_beat(OP_TICK, 4'd10);
        send_beat(OP_READ, 4'd15);
        send_beat(OP_CLEAR, 4'd15);
        send_beat(OP_READ, 4'd15);
        send_beat(OP_TICK, 4'd15);
        send_beat(OP_TICK, 4'd0);
        send_beat(OP_READ, 4'd9);
        send_beat(OP_CLEAR, 4'd6);

        // An interval of zero makes every tick run an update.
        write_interval(16'd0);
        repeat (150) send_random_beat();

        // Random phases, most with short intervals; one runs without gaps and
        // holds the output off long enough to back up the input.
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 5) write_interval(INTERVAL_W'($urandom_range(2, 65534)));
            else write_interval(INTERVAL_W'($urandom_range(1, 6)));
            if (phase == 2) begin
                no_idle = 1'b1;
                long_hold_req = 1'b1;
            end
            repeat (210) send_random_beat();
            no_idle = 1'b0;
        end

        // The largest interval; the ticks stay below it.
        write_interval(16'hFFFF);
        repeat (50) send_random_beat();

        s_tvalid <= 1'b0;
        for (int waited = 0; waited < DRAIN_MAX; waited++) begin
            @(posedge i_clk);
            if (pending == 0) break;
        end
        repeat (80) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            if (pending != 0) $display("%0d readings never arrived", pending);
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog for a block that stops responding.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mprm_pkg.sv
hw/rtl/mprm_front.sv
hw/rtl/mprm_cmd_fifo.sv
hw/rtl/mprm_back.sv
hw/rtl/multichannel_pulse_rate_meter_unit.sv
dv/mprm_checker.sv
dv/tb_multichannel_pulse_rate_meter_unit.sv
